@@ sv/format_spec_parser_macros.svh @@
// Assertion helpers for the format specification parser.
`ifndef FORMAT_SPEC_PARSER_MACROS_SVH
`define FORMAT_SPEC_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define FSP_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("format_spec_parser: assertion failed");

// Next-cycle implication, checked out of reset.
`define FSP_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("format_spec_parser: assertion failed");

`else

`define FSP_ASSERT_IMP(label, clk, rst_n, lhs, rhs)
`define FSP_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

@@ sv/fsp_pkg.sv @@
package fsp_pkg;

    // Native int size of the target; sets the saturation limits.
    localparam int NUM_BITS = 32;

    localparam logic [63:0] IMAX = (64'd1 << (NUM_BITS - 1)) - 64'd1;
    localparam logic [63:0] WIDTH_CAP64 =
        ((IMAX + 64'd1) > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : (IMAX + 64'd1);
    localparam logic [63:0] PREC_CAP64 =
        (IMAX > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : IMAX;
    localparam logic [31:0] WIDTH_CAP = WIDTH_CAP64[31:0];
    localparam logic [30:0] PREC_CAP  = PREC_CAP64[30:0];

    // flag_bits positions
    localparam int FB_STAR  = 0;
    localparam int FB_LEFT  = 1;
    localparam int FB_SIGN  = 2;
    localparam int FB_SPACE = 3;
    localparam int FB_ALT   = 4;
    localparam int FB_ZERO  = 5;
    localparam int FB_WIDTH = 6;
    localparam int FB_PREC  = 7;
    localparam int FB_UPPER = 8;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_FLAGS = 4'd1,
        PH_WIDTH = 4'd2,
        PH_DOT   = 4'd3,
        PH_PREC  = 4'd4,
        PH_LEN   = 4'd5,
        PH_HPEND = 4'd6,
        PH_LPEND = 4'd7,
        PH_SPEC  = 4'd8
    } fsp_phase_t;

    typedef enum logic [3:0] {
        LEN_NONE = 4'd0,
        LEN_HH   = 4'd1,
        LEN_H    = 4'd2,
        LEN_L    = 4'd3,
        LEN_LL   = 4'd4,
        LEN_J    = 4'd5,
        LEN_Z    = 4'd6,
        LEN_T    = 4'd7,
        LEN_BIGL = 4'd8
    } fsp_len_t;

    typedef enum logic [3:0] {
        ERR_NONE         = 4'd0,
        ERR_INPUT_FLAG   = 4'd1,
        ERR_INPUT_PREC   = 4'd2,
        ERR_BAD_LENGTH   = 4'd3,
        ERR_C_PREC       = 4'd4,
        ERR_WIDTH        = 4'd5,
        ERR_PREC         = 4'd6,
        ERR_FLAGS_PNP    = 4'd7,
        ERR_UNKNOWN_SPEC = 4'd8,
        ERR_NO_PERCENT   = 4'd9
    } fsp_err_t;

    typedef struct packed {
        logic [7:0]         ch;
        logic               start_req;
        logic signed [31:0] star_arg;
    } fsp_in_t;

    typedef struct packed {
        logic [7:0]  consumed;
        logic [8:0]  flag_bits;
        logic [31:0] field_width;
        logic [30:0] precision_value;
        logic [3:0]  length_code;
        logic [7:0]  spec_char;
        logic [3:0]  error_code;
    } fsp_out_t;

    // Held input beat as seen by the parser.
    typedef struct packed {
        logic    valid;
        fsp_in_t item;
    } fsp_in_beat_t;

    // Result produced by the parser in the cycle it consumes a beat.
    typedef struct packed {
        logic     valid;
        fsp_out_t item;
    } fsp_res_t;

endpackage

@@ sv/fsp_in_stage.sv @@
module fsp_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  fsp_pkg::fsp_in_t      in_item,
    input  logic                  take,
    output fsp_pkg::fsp_in_beat_t held
);
    import fsp_pkg::*;

    logic    full_reg;
    logic    full_next;
    fsp_in_t data_reg;
    logic    accept;

    // Refill in the same cycle the held beat is consumed.
    assign in_ready = !full_reg || take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        full_next = full_reg;
        if (accept)
        begin
            full_next = 1'b1;
        end
        else if (take)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= in_item;
        end
    end

    assign held.valid = full_reg;
    assign held.item  = data_reg;

endmodule

@@ sv/fsp_parser.sv @@
module fsp_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  fsp_pkg::fsp_in_beat_t held,
    input  logic                  take,
    output fsp_pkg::fsp_res_t     res
);
    import fsp_pkg::*;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;

    // Saturating a * 10 + d; a * 10 stays below 2^36.
    function automatic logic [31:0] acc_dec(
        input logic [31:0] a,
        input logic [3:0]  d,
        input logic [31:0] cap
    );
        logic [35:0] t;
        begin
            t = ({4'd0, a} << 3) + ({4'd0, a} << 1) + {32'd0, d};
            acc_dec = (t > {4'd0, cap}) ? cap : t[31:0];
        end
    endfunction

    logic        direction_reg;
    fsp_phase_t  phase_reg,  phase_next;
    logic [8:0]  flags_reg,  flags_next;
    logic [31:0] width_reg,  width_next;
    logic [30:0] prec_reg,   prec_next;
    fsp_len_t    length_reg, length_next;
    logic [7:0]  count_reg,  count_next;
    fsp_err_t    err_reg,    err_next;

    logic [7:0]  c;
    logic [31:0] star;
    logic [31:0] star_mag;
    logic [31:0] prec_acc32;
    logic [3:0]  dig;
    logic [7:0]  count_inc;
    logic        is_digit;
    logic        is_flag;
    logic [8:0]  flag_mask;
    logic        go_after_width;
    logic        go_len;
    logic        go_finish;
    fsp_len_t    fin_len;
    logic [8:0]  fin_flags;
    fsp_err_t    err_w;

    assign c          = held.item.ch;
    assign star       = held.item.star_arg;
    assign star_mag   = star[31] ? (32'd0 - star) : star;
    assign dig        = c[3:0];
    assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
    assign count_inc  = (count_reg == 8'hFF) ? count_reg : count_reg + 8'd1;
    assign prec_acc32 = acc_dec({1'b0, prec_reg}, dig, {1'b0, PREC_CAP});

    always_comb
    begin
        flag_mask = '0;
        unique case (c)
            CH_STAR:  flag_mask[FB_STAR]  = 1'b1;
            CH_MINUS: flag_mask[FB_LEFT]  = 1'b1;
            CH_PLUS:  flag_mask[FB_SIGN]  = 1'b1;
            CH_SPACE: flag_mask[FB_SPACE] = 1'b1;
            CH_HASH:  flag_mask[FB_ALT]   = 1'b1;
            CH_ZERO:  flag_mask[FB_ZERO]  = 1'b1;
            default:  flag_mask = '0;
        endcase
    end
    assign is_flag = |flag_mask;

    always_comb
    begin
        phase_next     = phase_reg;
        flags_next     = flags_reg;
        width_next     = width_reg;
        prec_next      = prec_reg;
        length_next    = length_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        err_w          = err_reg;
        go_after_width = 1'b0;
        go_len         = 1'b0;
        go_finish      = 1'b0;
        fin_len        = length_reg;
        fin_flags      = flags_reg;
        res            = '0;

        if (take)
        begin
            if (held.item.start_req)
            begin
                flags_next  = '0;
                width_next  = '0;
                prec_next   = '0;
                length_next = LEN_NONE;
                err_next    = ERR_NONE;
                if (c != CH_PERCENT)
                begin
                    count_next          = '0;
                    phase_next          = PH_IDLE;
                    res.valid           = 1'b1;
                    res.item.error_code = ERR_NO_PERCENT;
                end
                else
                begin
                    count_next = 8'd1;
                    phase_next = PH_FLAGS;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_FLAGS:
                    begin
                        if (is_flag)
                        begin
                            flags_next = flags_reg | flag_mask;
                            count_next = count_inc;
                            if (direction_reg)
                            begin
                                if (!flag_mask[FB_STAR] && err_w == ERR_NONE)
                                begin
                                    err_w = ERR_INPUT_FLAG;
                                end
                            end
                            else if (flag_mask[FB_STAR])
                            begin
                                // Star width: a negative argument means left adjust.
                                flags_next[FB_WIDTH] = 1'b1;
                                if (star[31])
                                begin
                                    flags_next[FB_LEFT] = 1'b1;
                                end
                                width_next = (star_mag > WIDTH_CAP) ? WIDTH_CAP : star_mag;
                            end
                        end
                        else if (c >= CH_ONE && c <= CH_NINE)
                        begin
                            flags_next[FB_WIDTH] = 1'b1;
                            width_next = {28'd0, dig};
                            phase_next = PH_WIDTH;
                            count_next = count_inc;
                        end
                        else
                        begin
                            go_after_width = 1'b1;
                        end
                    end
                    PH_WIDTH:
                    begin
                        if (is_digit)
                        begin
                            width_next = acc_dec(width_reg, dig, WIDTH_CAP);
                            count_next = count_inc;
                        end
                        else
                        begin
                            go_after_width = 1'b1;
                        end
                    end
                    PH_DOT:
                    begin
                        if (c == CH_STAR)
                        begin
                            // Consume the star; zero or negative drops the precision.
                            if (star != 32'd0 && !star[31])
                            begin
                                prec_next = (star[30:0] > PREC_CAP) ? PREC_CAP : star[30:0];
                            end
                            else
                            begin
                                flags_next[FB_PREC] = 1'b0;
                                prec_next = '0;
                            end
                            phase_next = PH_LEN;
                            count_next = count_inc;
                        end
                        else if (is_digit)
                        begin
                            prec_next  = prec_acc32[30:0];
                            phase_next = PH_PREC;
                            count_next = count_inc;
                        end
                        else
                        begin
                            go_len = 1'b1;
                        end
                    end
                    PH_PREC:
                    begin
                        if (is_digit)
                        begin
                            prec_next  = prec_acc32[30:0];
                            count_next = count_inc;
                        end
                        else
                        begin
                            go_len = 1'b1;
                        end
                    end
                    PH_LEN:
                    begin
                        go_len = 1'b1;
                    end
                    PH_HPEND:
                    begin
                        if (c == "h")
                        begin
                            length_next = LEN_HH;
                            phase_next  = PH_SPEC;
                            count_next  = count_inc;
                        end
                        else
                        begin
                            fin_len   = LEN_H;
                            go_finish = 1'b1;
                        end
                    end
                    PH_LPEND:
                    begin
                        if (c == "l")
                        begin
                            length_next = LEN_LL;
                            phase_next  = PH_SPEC;
                            count_next  = count_inc;
                        end
                        else
                        begin
                            fin_len   = LEN_L;
                            go_finish = 1'b1;
                        end
                    end
                    PH_SPEC:
                    begin
                        go_finish = 1'b1;
                    end
                    PH_IDLE:
                    begin
                        // drop stray characters between specifications
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase

                if (go_after_width)
                begin
                    if (c == CH_DOT)
                    begin
                        if (direction_reg && err_w == ERR_NONE)
                        begin
                            err_w = ERR_INPUT_PREC;
                        end
                        flags_next[FB_PREC] = 1'b1;
                        prec_next  = '0;
                        phase_next = PH_DOT;
                        count_next = count_inc;
                    end
                    else
                    begin
                        go_len = 1'b1;
                    end
                end

                if (go_len)
                begin
                    unique case (c)
                        "h":
                        begin
                            phase_next = PH_HPEND;
                            count_next = count_inc;
                        end
                        "l":
                        begin
                            phase_next = PH_LPEND;
                            count_next = count_inc;
                        end
                        "j":
                        begin
                            length_next = LEN_J;
                            phase_next  = PH_SPEC;
                            count_next  = count_inc;
                        end
                        "z":
                        begin
                            length_next = LEN_Z;
                            phase_next  = PH_SPEC;
                            count_next  = count_inc;
                        end
                        "t":
                        begin
                            length_next = LEN_T;
                            phase_next  = PH_SPEC;
                            count_next  = count_inc;
                        end
                        "L":
                        begin
                            length_next = LEN_BIGL;
                            phase_next  = PH_SPEC;
                            count_next  = count_inc;
                        end
                        default:
                        begin
                            go_finish = 1'b1;
                        end
                    endcase
                end

                if (go_finish)
                begin
                    fin_flags = flags_reg;
                    if (c >= CH_UP_A && c <= CH_UP_Z)
                    begin
                        fin_flags[FB_UPPER] = 1'b1;
                    end
                    unique case (c)
                        "d", "i", "o", "u", "x", "X":
                        begin
                            if (fin_len == LEN_BIGL && err_w == ERR_NONE)
                            begin
                                err_w = ERR_BAD_LENGTH;
                            end
                        end
                        "f", "F", "e", "E", "g", "G", "a", "A":
                        begin
                            if (fin_len != LEN_NONE && fin_len != LEN_BIGL
                                && err_w == ERR_NONE)
                            begin
                                err_w = ERR_BAD_LENGTH;
                            end
                        end
                        "c":
                        begin
                            if (fin_flags[FB_PREC] && err_w == ERR_NONE)
                            begin
                                err_w = ERR_C_PREC;
                            end
                            if (fin_len != LEN_NONE && fin_len != LEN_L && err_w == ERR_NONE)
                            begin
                                err_w = ERR_BAD_LENGTH;
                            end
                        end
                        "s", "[":
                        begin
                            if (fin_len != LEN_NONE && fin_len != LEN_L && err_w == ERR_NONE)
                            begin
                                err_w = ERR_BAD_LENGTH;
                            end
                        end
                        "p", "n", CH_PERCENT:
                        begin
                            if (fin_flags[FB_WIDTH] && err_w == ERR_NONE)
                            begin
                                err_w = ERR_WIDTH;
                            end
                            if (fin_flags[FB_PREC] && err_w == ERR_NONE)
                            begin
                                err_w = ERR_PREC;
                            end
                            if (fin_flags != 9'd0 && err_w == ERR_NONE)
                            begin
                                err_w = ERR_FLAGS_PNP;
                            end
                            if (fin_len != LEN_NONE && err_w == ERR_NONE)
                            begin
                                err_w = ERR_BAD_LENGTH;
                            end
                        end
                        default:
                        begin
                            if (err_w == ERR_NONE)
                            begin
                                err_w = ERR_UNKNOWN_SPEC;
                            end
                        end
                    endcase
                    res.valid                = 1'b1;
                    res.item.consumed        = count_reg;
                    res.item.flag_bits       = fin_flags;
                    res.item.field_width     = fin_flags[FB_WIDTH] ? width_reg : 32'd0;
                    res.item.precision_value = fin_flags[FB_PREC] ? prec_reg : 31'd0;
                    res.item.length_code     = fin_len;
                    res.item.spec_char       = c;
                    res.item.error_code      = err_w;
                    phase_next = PH_IDLE;
                end
                err_next = err_w;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            flags_reg     <= '0;
            width_reg     <= '0;
            prec_reg      <= '0;
            length_reg    <= LEN_NONE;
            count_reg     <= '0;
            err_reg       <= ERR_NONE;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                direction_reg <= cfg_wr_data;
            end
            phase_reg  <= phase_next;
            flags_reg  <= flags_next;
            width_reg  <= width_next;
            prec_reg   <= prec_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            err_reg    <= err_next;
        end
    end

endmodule

@@ sv/fsp_out_stage.sv @@
module fsp_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  fsp_pkg::fsp_res_t  res,
    output logic               space,
    output logic               out_valid,
    input  logic               out_ready,
    output fsp_pkg::fsp_out_t  out_item
);
    import fsp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    fsp_out_t data_reg;

    // Free when empty or when the held beat leaves this cycle.
    assign space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res.valid)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            data_reg <= res.item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = data_reg;

endmodule

@@ sv/format_spec_parser.sv @@
// Format specification parser: takes one format string character per input beat
// and parses a printf/scanf conversion (percent, flags, width, precision, length
// modifier, specifier). A beat with start_req begins a new specification; exactly
// one result beat comes out when the specifier arrives, or right away when the
// first character is not a percent sign. Between specifications, characters
// without start_req are dropped, and start_req in mid-parse abandons the old one
// silently. Throughput is one character per clock: the parser state updates
// straight from the input register, and results land in an output register.
// While a result waits in that register, the held character is not consumed,
// whether or not it would produce a result, so the input register fills and the
// input stalls until the result beat leaves. An accepted beat is held in the input
// register, parsed combinationally, and its result beat is registered in the output
// register. The direction register (0 output rules, 1 input rules) is written
// through cfg_wr_en and must only change while no parse is in flight.
module format_spec_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  fsp_pkg::fsp_in_t  in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output fsp_pkg::fsp_out_t out_item
);
    import fsp_pkg::*;

`include "format_spec_parser_macros.svh"

    fsp_in_beat_t held;
    fsp_res_t     res;
    logic         space;
    logic         take;

    // Consume the held beat only when a result, if any, has somewhere to go.
    assign take = held.valid && space;

    fsp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .take     (take),
        .held     (held)
    );

    fsp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .held        (held),
        .take        (take),
        .res         (res)
    );

    fsp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // A result only comes from a beat that is actually consumed.
    `FSP_ASSERT_IMP(a_res_needs_take, clk, rst_n, res.valid, take)
    // Backpressure on the input only while the holding register is occupied.
    `FSP_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !held.valid, in_ready)
    // A missing percent reports nothing but the error.
    `FSP_ASSERT_IMP(a_no_percent_clean, clk, rst_n,
        out_valid && (out_item.error_code == ERR_NO_PERCENT),
        (out_item.consumed == 8'd0) && (out_item.flag_bits == 9'd0))
    // Every result the parser produces always lands in the result register.
    `FSP_ASSERT_NEXT(a_result_lands, clk, rst_n, res.valid, out_valid)

endmodule

@@ sim/tb_format_spec_parser.sv @@
module tb_format_spec_parser;
    import fsp_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 9;
    // Extra wait after the last expected result so the pipe empties.
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD     = 250;
    localparam int PHASE_ITEMS   = 85;
    localparam int TIMEOUT_UNITS = 2_000_000;

    localparam logic [7:0] CH_PCT  = "%";
    localparam logic [7:0] CH_STAR = "*";
    localparam logic [7:0] CH_DOT  = ".";
    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_NINE = "9";

    // Pick lists for the random specifications.
    string flag_chars = "*-+ #0";
    string spec_chars = "diouxXfFeEgGaAcs[pn%";
    string len_opts[9] = '{"", "hh", "h", "l", "ll", "j", "z", "t", "L"};

    // Expected-result store plus a cycle-free model of the parser state.
    class spec_scoreboard;
        bit          dir_input;
        fsp_phase_t  phase = PH_IDLE;
        logic [8:0]  flags;
        logic [31:0] width_val;
        logic [30:0] prec_val;
        fsp_len_t    len;
        logic [7:0]  count;
        fsp_err_t    first_err;
        fsp_out_t    expected_q[$];
        int unsigned mismatches;
        int unsigned results_seen;

        task report(input string msg);
            mismatches++;
            $display("ERROR: %s", msg);
        endtask

        function void clear();
            flags     = '0;
            width_val = '0;
            prec_val  = '0;
            len       = LEN_NONE;
            count     = '0;
            first_err = ERR_NONE;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        // Keep only the first rule violation of a specification.
        function void note_err(fsp_err_t e);
            if (first_err == ERR_NONE)
                first_err = e;
        endfunction

        function void bump();
            if (count != 8'hFF)
                count++;
        endfunction

        function logic [31:0] width_digit(logic [31:0] a, logic [7:0] c);
            logic [63:0] v;
            v = 64'(a) * 64'd10 + 64'(c) - 64'(CH_ZERO);
            return (v > 64'(WIDTH_CAP)) ? WIDTH_CAP : v[31:0];
        endfunction

        function logic [30:0] prec_digit(logic [30:0] a, logic [7:0] c);
            logic [63:0] v;
            v = 64'(a) * 64'd10 + 64'(c) - 64'(CH_ZERO);
            return (v > 64'(PREC_CAP)) ? PREC_CAP : v[30:0];
        endfunction

        // Width from a star: a negative argument means left-adjust.
        function void take_width_star(logic [31:0] u);
            logic [31:0] mag;
            flags[FB_WIDTH] = 1'b1;
            if (u[31])
            begin
                flags[FB_LEFT] = 1'b1;
                mag = 32'd0 - u;
            end
            else
                mag = u;
            width_val = (mag > WIDTH_CAP) ? WIDTH_CAP : mag;
        endfunction

        // Specifier arrived: apply the per-conversion rules and queue the result.
        function void complete(logic [7:0] c);
            fsp_out_t   r;
            logic [8:0] f;
            f = flags;
            if (c >= "A" && c <= "Z")
                f[FB_UPPER] = 1'b1;
            case (c)
                "d", "i", "o", "u", "x", "X":
                    if (len == LEN_BIGL)
                        note_err(ERR_BAD_LENGTH);
                "f", "F", "e", "E", "g", "G", "a", "A":
                    if (len != LEN_NONE && len != LEN_BIGL)
                        note_err(ERR_BAD_LENGTH);
                "c":
                begin
                    if (f[FB_PREC])
                        note_err(ERR_C_PREC);
                    if (len != LEN_NONE && len != LEN_L)
                        note_err(ERR_BAD_LENGTH);
                end
                "s", "[":
                    if (len != LEN_NONE && len != LEN_L)
                        note_err(ERR_BAD_LENGTH);
                "p", "n", "%":
                begin
                    if (f[FB_WIDTH])
                        note_err(ERR_WIDTH);
                    if (f[FB_PREC])
                        note_err(ERR_PREC);
                    if (f != '0)
                        note_err(ERR_FLAGS_PNP);
                    if (len != LEN_NONE)
                        note_err(ERR_BAD_LENGTH);
                end
                default:
                    note_err(ERR_UNKNOWN_SPEC);
            endcase
            r.consumed        = count;
            r.flag_bits       = f;
            r.field_width     = f[FB_WIDTH] ? width_val : '0;
            r.precision_value = f[FB_PREC] ? prec_val : '0;
            r.length_code     = len;
            r.spec_char       = c;
            r.error_code      = first_err;
            expected_q.push_back(r);
            phase = PH_IDLE;
        endfunction

        function void length_stage(logic [7:0] c);
            case (c)
                "h": phase = PH_HPEND;
                "l": phase = PH_LPEND;
                "j":
                begin
                    len   = LEN_J;
                    phase = PH_SPEC;
                end
                "z":
                begin
                    len   = LEN_Z;
                    phase = PH_SPEC;
                end
                "t":
                begin
                    len   = LEN_T;
                    phase = PH_SPEC;
                end
                "L":
                begin
                    len   = LEN_BIGL;
                    phase = PH_SPEC;
                end
                default:
                begin
                    complete(c);
                    return;
                end
            endcase
            bump();
        endfunction

        function void after_width_stage(logic [7:0] c);
            if (c == CH_DOT)
            begin
                if (dir_input)
                    note_err(ERR_INPUT_PREC);
                flags[FB_PREC] = 1'b1;
                prec_val       = '0;
                phase          = PH_DOT;
                bump();
            end
            else
                length_stage(c);
        endfunction

        function void flags_stage(logic [7:0] c, logic [31:0] star);
            int pos;
            pos = -1;
            case (c)
                "*": pos = FB_STAR;
                "-": pos = FB_LEFT;
                "+": pos = FB_SIGN;
                " ": pos = FB_SPACE;
                "#": pos = FB_ALT;
                "0": pos = FB_ZERO;
                default: ;
            endcase
            if (pos >= 0)
            begin
                flags[pos] = 1'b1;
                if (dir_input)
                begin
                    if (pos != FB_STAR)
                        note_err(ERR_INPUT_FLAG);
                end
                else if (pos == FB_STAR)
                    take_width_star(star);
                bump();
            end
            else if (c >= "1" && c <= CH_NINE)
            begin
                flags[FB_WIDTH] = 1'b1;
                width_val       = 32'(c) - 32'(CH_ZERO);
                phase           = PH_WIDTH;
                bump();
            end
            else
                after_width_stage(c);
        endfunction

        // Advance the model by one accepted input beat.
        function void note_input(fsp_in_t it);
            fsp_out_t    r;
            logic [7:0]  c;
            logic [31:0] star;
            c    = it.ch;
            star = it.star_arg;
            if (it.start_req)
            begin
                clear();
                if (c != CH_PCT)
                begin
                    r            = '0;
                    r.error_code = ERR_NO_PERCENT;
                    expected_q.push_back(r);
                    phase = PH_IDLE;
                end
                else
                begin
                    count = 8'd1;
                    phase = PH_FLAGS;
                end
                return;
            end
            case (phase)
                PH_FLAGS:
                    flags_stage(c, star);
                PH_WIDTH:
                    if (is_digit(c))
                    begin
                        width_val = width_digit(width_val, c);
                        bump();
                    end
                    else
                        after_width_stage(c);
                PH_DOT:
                    if (c == CH_STAR)
                    begin
                        // Precision star is consumed; zero or negative drops it.
                        if (star != '0 && !star[31])
                            prec_val = (star > 32'(PREC_CAP)) ? PREC_CAP : star[30:0];
                        else
                        begin
                            flags[FB_PREC] = 1'b0;
                            prec_val       = '0;
                        end
                        phase = PH_LEN;
                        bump();
                    end
                    else if (is_digit(c))
                    begin
                        prec_val = prec_digit(prec_val, c);
                        phase    = PH_PREC;
                        bump();
                    end
                    else
                        length_stage(c);
                PH_PREC:
                    if (is_digit(c))
                    begin
                        prec_val = prec_digit(prec_val, c);
                        bump();
                    end
                    else
                        length_stage(c);
                PH_LEN:
                    length_stage(c);
                PH_HPEND:
                    if (c == "h")
                    begin
                        len   = LEN_HH;
                        phase = PH_SPEC;
                        bump();
                    end
                    else
                    begin
                        len = LEN_H;
                        complete(c);
                    end
                PH_LPEND:
                    if (c == "l")
                    begin
                        len   = LEN_LL;
                        phase = PH_SPEC;
                        bump();
                    end
                    else
                    begin
                        len = LEN_L;
                        complete(c);
                    end
                PH_SPEC:
                    complete(c);
                default: ;  // idle: drop the character
            endcase
        endfunction

        task compare_field(input string name, input logic [31:0] got, input logic [31:0] exp);
            if (got !== exp)
                report($sformatf("result %0d: %s is %0h, expected %0h",
                                 results_seen, name, got, exp));
        endtask

        task check_result(input fsp_out_t got);
            fsp_out_t exp_r;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with no expectation, spec_char %0h error %0d",
                                 got.spec_char, got.error_code));
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("consumed", 32'(got.consumed), 32'(exp_r.consumed));
            compare_field("flag_bits", 32'(got.flag_bits), 32'(exp_r.flag_bits));
            compare_field("field_width", got.field_width, exp_r.field_width);
            compare_field("precision_value", 32'(got.precision_value),
                          32'(exp_r.precision_value));
            compare_field("length_code", 32'(got.length_code), 32'(exp_r.length_code));
            compare_field("spec_char", 32'(got.spec_char), 32'(exp_r.spec_char));
            compare_field("error_code", 32'(got.error_code), 32'(exp_r.error_code));
            results_seen++;
        endtask

        task flag_missing();
            if (expected_q.size() != 0)
                report($sformatf("%0d expected results never arrived", expected_q.size()));
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_wr_en;
    logic     cfg_wr_data;
    logic     in_valid;
    logic     in_ready;
    fsp_in_t  in_item;
    logic     out_valid;
    logic     out_ready;
    fsp_out_t out_item;

    spec_scoreboard sb;
    fsp_in_t        stim_q[$];

    // Idle control used by the sender and the receiver.
    bit quiet;          // last phase: no gaps, no stalls
    bit gaps_on = 1'b1;
    int sent_beats;
    bit long_hold_req;  // ask the receiver for one long hold-off

    always #HALF_PERIOD clk = ~clk;

    format_spec_parser u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

    // ------------------------------------------------------------------
    // Stimulus building: characters go into stim_q, then get driven.
    // ------------------------------------------------------------------

    function automatic void add_char(logic [7:0] c, bit start, logic [31:0] star);
        fsp_in_t it;
        it.ch        = c;
        it.start_req = start;
        it.star_arg  = star;
        stim_q.push_back(it);
    endfunction

    // Star arguments lean toward the edges: most negative, -1, zero, largest.
    function automatic logic [31:0] pick_star();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'd0;
            4: return 32'($urandom_range(0, 40));
            5: return 32'd0 - 32'($urandom_range(1, 40));
            default: return $urandom();
        endcase
    endfunction

    // First character carries start_req; first star gets first_star, later ones later_star.
    function automatic void add_text(string s, logic [31:0] first_star,
                                     logic [31:0] later_star);
        bit          star_seen;
        logic [31:0] arg;
        star_seen = 1'b0;
        for (int i = 0; i < s.len(); i++)
        begin
            if (s[i] == CH_STAR)
            begin
                arg       = star_seen ? later_star : first_star;
                star_seen = 1'b1;
            end
            else
                arg = $urandom();
            add_char(s[i], i == 0, arg);
        end
    endfunction

    function automatic void add_digits(int n, bit zero_lead);
        for (int i = 0; i < n; i++)
            add_char(8'(CH_ZERO + $urandom_range((i == 0 && !zero_lead) ? 1 : 0, 9)),
                     1'b0, $urandom());
    endfunction

    // One random specification: mostly well-formed, the rest noise or broken.
    function automatic void add_random_spec();
        int    kind;
        int    n;
        int    first;
        string lm;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 76 || (kind >= 90 && kind < 95))
        begin
            first = stim_q.size();
            add_char(CH_PCT, 1'b1, $urandom());
            n = $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(4, 8);
            repeat (n)
                add_char(flag_chars[$urandom_range(0, flag_chars.len() - 1)],
                         1'b0, pick_star());
            case ($urandom_range(0, 4))
                1: add_char(CH_STAR, 1'b0, pick_star());
                2: add_digits($urandom_range(1, 3), 1'b0);
                3: add_digits($urandom_range(4, 12), 1'b0);
                4:
                begin
                    add_char(CH_STAR, 1'b0, pick_star());
                    add_digits($urandom_range(1, 3), 1'b0);
                end
                default: ;
            endcase
            case ($urandom_range(0, 4))
                1: add_char(CH_DOT, 1'b0, $urandom());
                2:
                begin
                    add_char(CH_DOT, 1'b0, $urandom());
                    add_char(CH_STAR, 1'b0, pick_star());
                end
                3:
                begin
                    add_char(CH_DOT, 1'b0, $urandom());
                    add_digits($urandom_range(1, 3), 1'b1);
                end
                4:
                begin
                    add_char(CH_DOT, 1'b0, $urandom());
                    add_digits($urandom_range(4, 12), 1'b1);
                end
                default: ;
            endcase
            lm = len_opts[$urandom_range(0, 8)];
            for (int i = 0; i < lm.len(); i++)
                add_char(lm[i], 1'b0, $urandom());
            if ($urandom_range(0, 9) == 0)
                add_char(8'($urandom_range(0, 255)), 1'b0, $urandom());
            else
                add_char(spec_chars[$urandom_range(0, spec_chars.len() - 1)], 1'b0, $urandom());
            // Broken: cut the tail so the next start abandons this one.
            if (kind >= 90)
            begin
                n = $urandom_range(1, stim_q.size() - first - 1);
                repeat (n)
                    void'(stim_q.pop_back());
            end
        end
        else if (kind < 83)
        begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_PCT)
                c = c ^ 8'h01;
            add_char(c, 1'b1, $urandom());
        end
        else if (kind < 90)
        begin
            add_char(CH_PCT, 1'b1, $urandom());
            repeat ($urandom_range(1, 6))
                add_char(8'($urandom_range(0, 255)), 1'b0, pick_star());
        end
        else
        begin
            repeat ($urandom_range(1, 3))
                add_char(8'($urandom_range(0, 255)), 1'b0, $urandom());
        end
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one beat, optionally after an idle burst; hold until accepted.
    task automatic send_item(input fsp_in_t it);
        int n;
        sent_beats++;
        if (sent_beats % 48 == 0)
            gaps_on = $urandom_range(0, 3) != 0;
        if (!quiet && gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            n = $urandom_range(1, 10);
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic drive_stream();
        foreach (stim_q[i])
            send_item(stim_q[i]);
        stim_q.delete();
    endtask

    // Drop valid, wait for every expected beat, then let the pipe empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_direction(input bit d);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= d;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.dir_input = d;
    endtask

    // Random characters up to the target, closed with a plain percent
    // conversion so the parser ends up idle before the next register write.
    task automatic random_phase(input int target);
        while (stim_q.size() < target)
            add_random_spec();
        add_text("%%", 32'd0, 32'd0);
        drive_stream();
        settle();
    endtask

    // Receiver: random stall bursts, quiet windows, and one long hold-off
    // counted here while the sender keeps offering beats.
    initial
    begin
        int stall_left;
        int hold_left;
        int window;
        bit stalls_on;
        stall_left = 0;
        hold_left  = 0;
        window     = 0;
        stalls_on  = 1'b1;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            window++;
            if (window % 64 == 0)
                stalls_on = $urandom_range(0, 3) != 0;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                out_ready    <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet && stalls_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Result monitor: sample before this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_item);
    end

    initial
    begin
        #(TIMEOUT_UNITS);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        in_valid    <= 1'b0;
        in_item     <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, output rules.
        set_direction(1'b0);
        add_text("%*.*hhd", 32'h8000_0000, 32'd0);      // width star at its most negative
        add_text("%-+ #0*.*Lf", 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        add_text("%*12d", 32'hFFFF_FFFD, 32'd0);         // digits replace a star width
        add_text("%.c", 32'd0, 32'd0);                   // dot alone on %c
        add_text("%5%", 32'd0, 32'd0);
        add_text("%lld", 32'd0, 32'd0);
        add_char(8'hFF, 1'b1, 32'hFFFF_FFFF);            // no leading percent
        add_char(CH_PCT, 1'b1, 32'd0);
        add_char(8'h00, 1'b0, 32'd0);                    // NUL taken as the specifier
        add_char("x", 1'b0, 32'h5555_5555);              // idle, ignored
        add_text("%-", 32'd0, 32'd0);
        add_text("%p", 32'd0, 32'd0);                    // restart abandons the previous
        add_text("%jz", 32'd0, 32'd0);
        drive_stream();
        settle();

        // Directed, input rules.
        set_direction(1'b1);
        add_text("%*5.3hs", 32'd9, 32'd0);
        add_text("%+d", 32'd0, 32'd0);
        add_text("%*.*d", 32'd7, 32'hFFFF_FFFB);
        add_text("%Lx", 32'd0, 32'd0);
        drive_stream();
        settle();

        // Random phases over both directions.
        set_direction(1'b0);
        random_phase(PHASE_ITEMS);

        set_direction(1'b1);
        long_hold_req = 1'b1;
        random_phase(PHASE_ITEMS);

        set_direction(1'b0);
        random_phase(PHASE_ITEMS);

        quiet = 1'b1;
        set_direction(1'b1);
        random_phase(PHASE_ITEMS);

        sb.flag_missing();
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ format_spec_parser.f @@
+incdir+sv
sv/fsp_pkg.sv
sv/fsp_in_stage.sv
sv/fsp_parser.sv
sv/fsp_out_stage.sv
sv/format_spec_parser.sv
sim/tb_format_spec_parser.sv
